>>> hw/rtl/jch_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jch_pkg: jump consistent hash shared definitions
// Widths, the key step multiplier and the status carried from the divider.
// ----------------------------------------------------------------------------
package jch_pkg;

    localparam int KEY_W     = 64;
    localparam int BKT_W     = 31;
    localparam int RES_W     = 32;
    localparam int HALF_W    = 32;
    localparam int DIV_STEPS = BKT_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [KEY_W-1:0]  KEY_MULT = 64'd2862933555777941757;
    localparam logic [HALF_W-1:0] MULT_LO  = KEY_MULT[HALF_W-1:0];
    localparam logic [HALF_W-1:0] MULT_HI  = KEY_MULT[KEY_W-1:HALF_W];

    typedef struct packed {
        logic done;
    } div_stat_t;

endpackage : jch_pkg
`default_nettype wire

>>> hw/rtl/jch_mul32.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jch_mul32: shared 32x32 multiplier
// Unsigned product, registered in the cycle after the operands are presented.
// ----------------------------------------------------------------------------
module jch_mul32
    import jch_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic [HALF_W-1:0]     a,
    input  wire logic [HALF_W-1:0]     b,
    output logic      [2*HALF_W-1:0]   p
);

    logic [2*HALF_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule : jch_mul32
`default_nettype wire

>>> hw/rtl/jch_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jch_div: bit-serial restoring divider
// Computes floor((numer << 31) / divisor), one quotient bit per cycle, for
// numer below divisor so that the quotient fits in 31 bits.
// ----------------------------------------------------------------------------
module jch_div
    import jch_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [HALF_W-1:0]     numer,
    input  wire logic [HALF_W-1:0]     divisor,
    output logic      [BKT_W-1:0]      quot,
    output div_stat_t                  stat
);

    logic [HALF_W:0]      rem_reg,  rem_next;
    logic [HALF_W:0]      dvs_reg,  dvs_next;
    logic [BKT_W-1:0]     quot_reg, quot_next;
    logic [DIV_CNT_W-1:0] cnt_reg,  cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [HALF_W:0]      rem_sh;

    always_comb
    begin
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_sh    = {rem_reg[HALF_W-1:0], 1'b0};
        if (start)
        begin
            rem_next  = {1'b0, numer};
            dvs_next  = {1'b0, divisor};
            quot_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= dvs_reg)
            begin
                rem_next  = rem_sh - dvs_reg;
                quot_next = {quot_reg[BKT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                quot_next = {quot_reg[BKT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        quot_reg <= quot_next;
    end

    assign quot      = quot_reg;
    assign stat.done = done_reg;

endmodule : jch_div
`default_nettype wire

>>> hw/rtl/jump_consistent_hash_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jump_consistent_hash_core: jump consistent hash bucket selector
// Maps a 64-bit key and a bucket count to a bucket with exact integer math.
// ----------------------------------------------------------------------------
// Takes one item at a time and stalls its input until the result is loaded
// into the output register. Each jump advances the key through the shared
// 32x32 multiplier (three partial products and a final add), tests the next
// candidate against the bucket count with one more product and, when the
// loop goes on, runs the bit-serial divider and hands back the quotient as
// the next candidate. A key makes about ln(buckets) + 1 jumps; a bucket
// count of zero returns -1 with no jump.
// ----------------------------------------------------------------------------
module jump_consistent_hash_core
    import jch_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [KEY_W-1:0]      key,
    input  wire logic [BKT_W-1:0]      buckets,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic      [RES_W-1:0]      bucket
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_LL,
        S_MUL_LH,
        S_MUL_HL,
        S_MUL_ADD,
        S_CMP_MUL,
        S_CMP,
        S_DIV,
        S_FINISH
    } state_t;

    state_t             state_reg,     state_next;
    logic               out_valid_reg, out_valid_next;
    logic [RES_W-1:0]   bucket_reg,    bucket_next;
    logic [KEY_W-1:0]   key_reg,       key_next;
    logic [KEY_W-1:0]   acc_reg,       acc_next;
    logic [BKT_W-1:0]   lim_reg,       lim_next;
    logic [BKT_W-1:0]   b_reg,         b_next;
    logic [RES_W-1:0]   res_reg,       res_next;

    logic [HALF_W-1:0]   mul_a;
    logic [HALF_W-1:0]   mul_b;
    logic [2*HALF_W-1:0] mul_p;
    logic [HALF_W-1:0]   b_plus1;
    logic [HALF_W-1:0]   dvs;
    logic [KEY_W-1:0]    numer_full;
    logic                div_start;
    logic [BKT_W-1:0]    div_q;
    div_stat_t           div_stat;

    assign b_plus1    = {1'b0, b_reg} + HALF_W'(1);
    assign dvs        = {1'b0, key_reg[KEY_W-1:KEY_W-BKT_W]} + HALF_W'(1);
    assign numer_full = {1'b0, b_plus1, {BKT_W{1'b0}}};

    jch_mul32 u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    jch_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .numer   (b_plus1),
        .divisor (dvs),
        .quot    (div_q),
        .stat    (div_stat)
    );

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_MUL_LL:
            begin
                mul_a = key_reg[HALF_W-1:0];
                mul_b = MULT_LO;
            end
            S_MUL_LH:
            begin
                mul_a = key_reg[HALF_W-1:0];
                mul_b = MULT_HI;
            end
            S_MUL_HL:
            begin
                mul_a = key_reg[KEY_W-1:HALF_W];
                mul_b = MULT_LO;
            end
            S_CMP_MUL:
            begin
                mul_a = {1'b0, lim_reg};
                mul_b = dvs;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        bucket_next    = bucket_reg;
        key_next       = key_reg;
        acc_next       = acc_reg;
        lim_next       = lim_reg;
        b_next         = b_reg;
        res_next       = res_reg;
        div_start      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    key_next = key;
                    lim_next = buckets;
                    b_next   = '0;
                    if (buckets == '0)
                    begin
                        res_next   = '1;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_MUL_LL;
                    end
                end
            end
            S_MUL_LL:
            begin
                state_next = S_MUL_LH;
            end
            S_MUL_LH:
            begin
                acc_next   = mul_p;
                state_next = S_MUL_HL;
            end
            S_MUL_HL:
            begin
                acc_next   = acc_reg + {mul_p[HALF_W-1:0], {HALF_W{1'b0}}};
                state_next = S_MUL_ADD;
            end
            S_MUL_ADD:
            begin
                key_next   = acc_reg + {mul_p[HALF_W-1:0], {HALF_W{1'b0}}} + KEY_W'(1);
                state_next = S_CMP_MUL;
            end
            S_CMP_MUL:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (numer_full < mul_p)
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
                else
                begin
                    res_next   = {1'b0, b_reg};
                    state_next = S_FINISH;
                end
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    b_next     = div_q;
                    state_next = S_MUL_LL;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    bucket_next    = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bucket_reg <= bucket_next;
        key_reg    <= key_next;
        acc_reg    <= acc_next;
        lim_reg    <= lim_next;
        b_reg      <= b_next;
        res_reg    <= res_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign bucket    = bucket_reg;

endmodule : jump_consistent_hash_core
`default_nettype wire

>>> hw/rtl/jch_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jch_checker: port-level checks for the jump consistent hash core
// Watches the handshakes and result range; bound to the top level.
// ----------------------------------------------------------------------------
module jch_checker
    import jch_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic                  in_stall,
    input  wire logic                  out_valid,
    input  wire logic                  out_stall,
    input  wire logic [RES_W-1:0]      bucket
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(bucket))
        else $error("stalled output item changed or dropped");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (bucket[RES_W-1] == 1'b0) || (bucket == {RES_W{1'b1}}))
        else $error("bucket outside valid range");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not held off after accepting an item");

    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall) && !in_stall)
        else $error("result appeared without an item in flight");

endmodule : jch_checker

bind jump_consistent_hash_core jch_checker u_jch_checker (.*);
`default_nettype wire
